/* sv/srrd_pkg.sv */
// Shared types and constants of the shortest-request dispatcher.
`default_nettype none

package srrd_pkg;

    // Most results that one input transaction may cause.
    localparam int MAX_RESULTS = 16;
    localparam int K_W         = $clog2(MAX_RESULTS + 1);

    typedef enum logic [1:0] {
        ST_ASSIGNED  = 2'd0,
        ST_DROPPED   = 2'd1,
        ST_REQ_FULL  = 2'd2,
        ST_RING_FULL = 2'd3
    } status_t;

    localparam logic FUNC_REQUEST  = 1'b0;
    localparam logic FUNC_ELEVATOR = 1'b1;

    typedef struct packed {
        logic [7:0] id;
        logic [6:0] start_floor;
        logic [6:0] end_floor;
        logic [7:0] travel;
    } req_entry_t;

    typedef struct packed {
        logic [3:0] id;
        logic [6:0] highest;
    } car_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic check;
        logic scan;
        logic shift;
        logic rotate;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic dispatch_ok;
        logic scan_done;
        logic shift_done;
        logic rot_done;
    } sts_t;

endpackage

`default_nettype wire

/* sv/shortest_request_round_robin_dispatch_top.sv */
// Top level of the shortest-request dispatcher with a round-robin elevator ring.
`default_nettype none

// A transaction is accepted at a rising edge with start high and busy low. func selects
// whether it queues a travel request or adds an elevator to the ring. After every
// transaction the block dispatches waiting requests while both a request and an elevator
// exist, at most 16 results per transaction: it scans the request memory for the smallest
// absolute travel (the earliest arrival wins a tie), closes the gap it leaves, then rotates
// the ring one car per cycle until a car that can serve the request has moved to the back.
// A request that no car can serve, zero travel included, is dropped with its own status.
// Every result is shown for one cycle with valid high, and last marks the final result of
// the transaction; the receiver cannot stall, so it must take each result as it appears.
// Timing: a transaction that causes no dispatch keeps busy high only while the dispatch
// check runs. Each dispatch passes the check, the scan of the request memory, the shift
// that closes the gap and the ring rotation in that order, so results of one transaction
// are never back to back, and busy stays high until the last one is out.
module shortest_request_round_robin_dispatch_top #(
    parameter int REQUEST_DEPTH = 16,
    parameter int RING_DEPTH    = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              func,
    input  wire logic [7:0]        request_id,
    input  wire logic [6:0]        start_floor,
    input  wire logic [6:0]        end_floor,
    input  wire logic signed [7:0] travel,
    input  wire logic [3:0]        elevator_id,
    input  wire logic [6:0]        highest_floor,
    output logic                   valid,
    output logic [7:0]             out_request_id,
    output logic [3:0]             out_elevator_id,
    output logic [1:0]             status,
    output logic                   last
);
    import srrd_pkg::*;

    // Commands and status between the controller and the datapath.
    cmd_t cmd;
    sts_t sts;

    srrd_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // The datapath keeps the raw travel bits; its magnitude logic reads the sign bit.
    srrd_dp #(
        .REQUEST_DEPTH (REQUEST_DEPTH),
        .RING_DEPTH    (RING_DEPTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .sts             (sts),
        .func            (func),
        .request_id      (request_id),
        .start_floor     (start_floor),
        .end_floor       (end_floor),
        .travel          ($unsigned(travel)),
        .elevator_id     (elevator_id),
        .highest_floor   (highest_floor),
        .valid           (valid),
        .out_request_id  (out_request_id),
        .out_elevator_id (out_elevator_id),
        .status          (status),
        .last            (last)
    );

endmodule

`default_nettype wire

/* sv/srrd_ctrl.sv */
// Controller state machine of the shortest-request dispatcher.
`default_nettype none

module srrd_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire srrd_pkg::sts_t sts,
    output srrd_pkg::cmd_t     cmd,
    output logic               busy
);
    import srrd_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CHECK  = 5'b00010,
        S_SCAN   = 5'b00100,
        S_SHIFT  = 5'b01000,
        S_ROTATE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = sts.dispatch_ok ? S_SCAN : S_IDLE;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = S_SHIFT;
                end
            end
            S_SHIFT:
            begin
                cmd.shift = 1'b1;
                if (sts.shift_done)
                begin
                    state_next = S_ROTATE;
                end
            end
            S_ROTATE:
            begin
                cmd.rotate = 1'b1;
                if (sts.rot_done)
                begin
                    state_next = S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // An accepted transaction always passes through the dispatch check.
    a_accept_checks: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_CHECK))
        else $error("accepted transaction did not reach the dispatch check");

endmodule

`default_nettype wire

/* sv/srrd_dp.sv */
// Datapath of the shortest-request dispatcher: request memory, elevator ring, results.
`default_nettype none

module srrd_dp #(
    parameter int REQUEST_DEPTH = 16,
    parameter int RING_DEPTH    = 8
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire srrd_pkg::cmd_t cmd,
    output srrd_pkg::sts_t      sts,
    input  wire logic           func,
    input  wire logic [7:0]     request_id,
    input  wire logic [6:0]     start_floor,
    input  wire logic [6:0]     end_floor,
    input  wire logic [7:0]     travel,
    input  wire logic [3:0]     elevator_id,
    input  wire logic [6:0]     highest_floor,
    output logic                valid,
    output logic [7:0]          out_request_id,
    output logic [3:0]          out_elevator_id,
    output logic [1:0]          status,
    output logic                last
);
    import srrd_pkg::*;

    localparam int AW = (REQUEST_DEPTH > 1) ? $clog2(REQUEST_DEPTH) : 1;
    localparam int CW = $clog2(REQUEST_DEPTH + 1);
    localparam int HW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int RW = $clog2(RING_DEPTH + 1);
    localparam int SW = ((HW > RW) ? HW : RW) + 1;

    function automatic logic [7:0] travel_mag(input logic [7:0] t);
        return t[7] ? (~t + 8'd1) : t;
    endfunction

    function automatic logic can_serve(input req_entry_t r, input car_t c);
        return (!r.travel[7] && (r.travel != 8'd0) && (r.end_floor <= c.highest))
            || (r.travel[7] && (r.start_floor <= c.highest));
    endfunction

    // Storage.
    req_entry_t mem [REQUEST_DEPTH];
    car_t       ring_reg [RING_DEPTH];
    req_entry_t rd_data_reg;

    // Control registers.
    logic [CW-1:0]  req_count_reg,  req_count_next;
    logic [RW-1:0]  ring_count_reg, ring_count_next;
    logic [HW-1:0]  head_reg,       head_next;
    logic [K_W-1:0] k_reg,          k_next;
    logic [CW-1:0]  scan_idx_reg,   scan_idx_next;
    logic           cmp_vld_reg,    cmp_vld_next;
    logic [AW-1:0]  cmp_idx_reg,    cmp_idx_next;
    logic [CW-1:0]  shift_idx_reg,  shift_idx_next;
    logic           wr_vld_reg,     wr_vld_next;
    logic [AW-1:0]  wr_idx_reg,     wr_idx_next;
    logic [RW-1:0]  rot_n_reg,      rot_n_next;
    logic           valid_reg,      valid_next;

    // Payload registers.
    req_entry_t     best_reg,       best_next;
    logic [AW-1:0]  best_idx_reg,   best_idx_next;
    logic [7:0]     rid_reg,        rid_next;
    logic [3:0]     eid_reg,        eid_next;
    status_t        status_reg,     status_next;
    logic           last_reg,       last_next;

    logic           req_full;
    logic           ring_full;
    logic [SW-1:0]  tail_sum;
    logic [SW-1:0]  tail_wrap;
    logic [HW-1:0]  tail_idx;
    logic [SW-1:0]  head_sum;
    logic [HW-1:0]  head_inc;
    logic           scan_issue;
    logic           shift_issue;
    logic           take;
    logic [CW-1:0]  shift_prev;
    car_t           car;
    logic           serve;
    logic           rot_last;
    logic           emit_more;

    logic           mem_we;
    logic [AW-1:0]  mem_waddr;
    req_entry_t     mem_wdata;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;
    logic           ring_we;
    car_t           ring_wdata;
    req_entry_t     new_req;
    car_t           new_car;

    assign req_full  = (req_count_reg == CW'(REQUEST_DEPTH));
    assign ring_full = (ring_count_reg == RW'(RING_DEPTH));

    // Tail slot of the ring and the next head slot, each kept below the ring depth.
    assign tail_sum  = SW'(head_reg) + SW'(ring_count_reg);
    assign tail_wrap = (tail_sum >= SW'(RING_DEPTH)) ? (tail_sum - SW'(RING_DEPTH)) : tail_sum;
    assign tail_idx  = tail_wrap[HW-1:0];
    assign head_sum  = SW'(head_reg) + SW'(1);
    assign head_inc  = (head_sum >= SW'(RING_DEPTH)) ? HW'(0) : head_sum[HW-1:0];

    assign new_req.id          = request_id;
    assign new_req.start_floor = start_floor;
    assign new_req.end_floor   = end_floor;
    assign new_req.travel      = travel;
    assign new_car.id          = elevator_id;
    assign new_car.highest     = highest_floor;

    assign scan_issue  = cmd.scan && (scan_idx_reg < req_count_reg);
    assign shift_issue = cmd.shift && (shift_idx_reg < req_count_reg);
    assign shift_prev  = shift_idx_reg - CW'(1);
    assign take        = (cmp_idx_reg == '0)
                      || (travel_mag(rd_data_reg.travel) < travel_mag(best_reg.travel));

    assign car      = ring_reg[head_reg];
    assign serve    = can_serve(best_reg, car);
    assign rot_last = ((rot_n_reg + RW'(1)) == ring_count_reg);

    // Another dispatch follows this one when requests remain and the limit is not reached.
    assign emit_more = ((k_reg + K_W'(1)) != K_W'(MAX_RESULTS)) && (req_count_reg != '0);

    assign best_next     = (cmd.scan && cmp_vld_reg && take) ? rd_data_reg : best_reg;
    assign best_idx_next = (cmd.scan && cmp_vld_reg && take) ? cmp_idx_reg : best_idx_reg;

    assign sts.dispatch_ok = (req_count_reg != '0) && (ring_count_reg != '0)
                          && (k_reg < K_W'(MAX_RESULTS));
    assign sts.scan_done   = cmd.scan && cmp_vld_reg
                          && (CW'(cmp_idx_reg) == (req_count_reg - CW'(1)));
    assign sts.shift_done  = cmd.shift && !shift_issue;
    assign sts.rot_done    = cmd.rotate && (serve || rot_last);

    always_comb
    begin
        req_count_next  = req_count_reg;
        ring_count_next = ring_count_reg;
        head_next       = head_reg;
        k_next          = k_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        shift_idx_next  = shift_idx_reg;
        wr_vld_next     = wr_vld_reg;
        wr_idx_next     = wr_idx_reg;
        rot_n_next      = rot_n_reg;
        valid_next      = 1'b0;
        rid_next        = rid_reg;
        eid_next        = eid_reg;
        status_next     = status_reg;
        last_next       = last_reg;
        mem_we          = 1'b0;
        mem_waddr       = wr_idx_reg;
        mem_wdata       = rd_data_reg;
        ring_we         = 1'b0;
        ring_wdata      = car;

        if (cmd.load)
        begin
            k_next = '0;
            if (func == FUNC_REQUEST)
            begin
                if (req_full)
                begin
                    valid_next  = 1'b1;
                    rid_next    = request_id;
                    eid_next    = 4'd0;
                    status_next = ST_REQ_FULL;
                    last_next   = (ring_count_reg == '0);
                    k_next      = K_W'(1);
                end
                else
                begin
                    mem_we         = 1'b1;
                    mem_waddr      = req_count_reg[AW-1:0];
                    mem_wdata      = new_req;
                    req_count_next = req_count_reg + CW'(1);
                end
            end
            else
            begin
                if (ring_full)
                begin
                    valid_next  = 1'b1;
                    rid_next    = 8'd0;
                    eid_next    = 4'd0;
                    status_next = ST_RING_FULL;
                    last_next   = (req_count_reg == '0);
                    k_next      = K_W'(1);
                end
                else
                begin
                    ring_we         = 1'b1;
                    ring_wdata      = new_car;
                    ring_count_next = ring_count_reg + RW'(1);
                end
            end
        end

        if (cmd.check)
        begin
            scan_idx_next = '0;
            cmp_vld_next  = 1'b0;
        end

        // Scan: one read issued and one compare made per cycle.
        if (cmd.scan)
        begin
            if (scan_issue)
            begin
                scan_idx_next = scan_idx_reg + CW'(1);
            end
            cmp_vld_next = scan_issue;
            cmp_idx_next = scan_idx_reg[AW-1:0];
            if (sts.scan_done)
            begin
                shift_idx_next = CW'(best_idx_next) + CW'(1);
                wr_vld_next    = 1'b0;
            end
        end

        // Close the gap: each entry after the chosen one moves down one slot.
        if (cmd.shift)
        begin
            if (shift_issue)
            begin
                shift_idx_next = shift_idx_reg + CW'(1);
            end
            wr_vld_next = shift_issue;
            wr_idx_next = shift_prev[AW-1:0];
            if (wr_vld_reg)
            begin
                mem_we    = 1'b1;
                mem_waddr = wr_idx_reg;
                mem_wdata = rd_data_reg;
            end
            if (sts.shift_done)
            begin
                req_count_next = req_count_reg - CW'(1);
                rot_n_next     = '0;
            end
        end

        // Rotate: the front car moves to the back each cycle.
        if (cmd.rotate)
        begin
            ring_we    = 1'b1;
            ring_wdata = car;
            head_next  = head_inc;
            rot_n_next = rot_n_reg + RW'(1);
            if (sts.rot_done)
            begin
                valid_next  = 1'b1;
                rid_next    = best_reg.id;
                eid_next    = serve ? car.id : 4'd0;
                status_next = serve ? ST_ASSIGNED : ST_DROPPED;
                last_next   = !emit_more;
                k_next      = k_reg + K_W'(1);
            end
        end
    end

    assign mem_re    = scan_issue || shift_issue;
    assign mem_raddr = cmd.scan ? scan_idx_reg[AW-1:0] : shift_idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_reg[tail_idx] <= ring_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_count_reg  <= '0;
            ring_count_reg <= '0;
            head_reg       <= '0;
            k_reg          <= '0;
            scan_idx_reg   <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            shift_idx_reg  <= '0;
            wr_vld_reg     <= 1'b0;
            wr_idx_reg     <= '0;
            rot_n_reg      <= '0;
            valid_reg      <= 1'b0;
        end
        else
        begin
            req_count_reg  <= req_count_next;
            ring_count_reg <= ring_count_next;
            head_reg       <= head_next;
            k_reg          <= k_next;
            scan_idx_reg   <= scan_idx_next;
            cmp_vld_reg    <= cmp_vld_next;
            cmp_idx_reg    <= cmp_idx_next;
            shift_idx_reg  <= shift_idx_next;
            wr_vld_reg     <= wr_vld_next;
            wr_idx_reg     <= wr_idx_next;
            rot_n_reg      <= rot_n_next;
            valid_reg      <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        rid_reg      <= rid_next;
        eid_reg      <= eid_next;
        status_reg   <= status_next;
        last_reg     <= last_next;
    end

    assign valid           = valid_reg;
    assign out_request_id  = rid_reg;
    assign out_elevator_id = eid_reg;
    assign status          = status_reg;
    assign last            = last_reg;

    a_req_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        req_count_reg <= CW'(REQUEST_DEPTH))
        else $error("request count beyond store depth");

    a_ring_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        ring_count_reg <= RW'(RING_DEPTH))
        else $error("ring count beyond ring depth");

    a_rotate_needs_car: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rotate |-> (ring_count_reg != '0))
        else $error("ring rotated while empty");

    a_unassigned_no_car: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && (status_reg != ST_ASSIGNED)) |-> (eid_reg == 4'd0))
        else $error("elevator id given on a result that was not assigned");

    a_one_result_per_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        sts.rot_done |=> (valid_reg && !$past(valid_reg)))
        else $error("dispatch did not produce exactly one result strobe");

endmodule

`default_nettype wire
